@@ rtl/tstc_pkg.sv @@
`default_nettype none

package tstc_pkg;

    // Number of points spanned by the recent-direction vector.
    localparam int HISTORY_DEPTH = 5;
    // Stored points before the latest one.
    localparam int HIST_LEN = HISTORY_DEPTH - 1;
    // Point counter saturates at HISTORY_DEPTH + 1.
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 2);

    // Field and register widths.
    localparam int COORD_W = 16;
    localparam int DIFF_W = COORD_W + 1;
    localparam int SQ_W = 2 * COORD_W;
    localparam int LEN_W = SQ_W + 1;
    localparam int LEN_CFG_W = 12;
    localparam int TRIG_W = 17;
    localparam int CFG_W = 17;
    localparam int CFG_IDX_W = 2;
    localparam int Q16_SHIFT = 16;
    localparam int PROD_W = TRIG_W + LEN_W;
    localparam int XQ_W = SQ_W + Q16_SHIFT;
    localparam int MIN_SQ_W = 2 * LEN_CFG_W;

    // Queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // Register reset values.
    localparam logic [LEN_CFG_W-1:0] TAP_TOL_RST = LEN_CFG_W'(20);
    localparam logic [LEN_CFG_W-1:0] MIN_LEN_RST = LEN_CFG_W'(30);
    localparam logic [TRIG_W-1:0] COS_SQ_RST = TRIG_W'(55938);
    localparam logic [TRIG_W-1:0] SIN_SQ_RST = TRIG_W'(9598);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TAP_TOL = 2'd0,
        CFG_MIN_LEN = 2'd1,
        CFG_COS_SQ  = 2'd2,
        CFG_SIN_SQ  = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        DIR_UNKNOWN = 3'd0,
        DIR_RIGHT   = 3'd1,
        DIR_DOWN    = 3'd2,
        DIR_LEFT    = 3'd3,
        DIR_UP      = 3'd4
    } t_dir;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_point;

    // Two's complement vector, one bit wider than a coordinate.
    typedef struct packed {
        logic [DIFF_W-1:0] dx;
        logic [DIFF_W-1:0] dy;
    } t_vec;

    // Word handed from the front part to the back part.
    typedef struct packed {
        logic still_tap;
        logic use_recent;
        t_vec ovr;
        t_vec rec;
    } t_qent;

    typedef struct packed {
        logic [LEN_CFG_W-1:0] min_len;
        logic [TRIG_W-1:0]    cos_sq;
        logic [TRIG_W-1:0]    sin_sq;
    } t_cls_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ,
        S_SUM,
        S_MUL,
        S_DEC,
        S_OUT
    } t_bstate;

endpackage

`default_nettype wire

@@ rtl/tstc_front.sv @@
`default_nettype none

module tstc_front (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic [tstc_pkg::LEN_CFG_W-1:0]       i_tap_tol,
    input  wire logic                                 i_valid,
    input  wire logic                                 i_full,
    input  wire logic                                 i_gesture_start,
    input  wire logic signed [tstc_pkg::COORD_W-1:0]  i_pos_x,
    input  wire logic signed [tstc_pkg::COORD_W-1:0]  i_pos_y,
    input  wire logic signed [tstc_pkg::COORD_W-1:0]  i_raw_x,
    input  wire logic signed [tstc_pkg::COORD_W-1:0]  i_raw_y,
    output tstc_pkg::t_qent                           o_ent,
    output logic                                      o_push
);

    tstc_pkg::t_point r_first_pos;
    tstc_pkg::t_point n_first_pos;
    tstc_pkg::t_point r_first_raw;
    tstc_pkg::t_point n_first_raw;
    tstc_pkg::t_point r_hist [tstc_pkg::HIST_LEN];
    logic r_tap;
    logic n_tap;
    logic [tstc_pkg::CNT_W-1:0] r_count;
    logic [tstc_pkg::CNT_W-1:0] n_count;

    logic [tstc_pkg::DIFF_W-1:0] w_rdx;
    logic [tstc_pkg::DIFF_W-1:0] w_rdy;
    logic [tstc_pkg::DIFF_W-1:0] w_rdx_abs;
    logic [tstc_pkg::DIFF_W-1:0] w_rdy_abs;
    logic w_exceed;
    logic w_accept;

    assign w_accept = i_valid && !i_full;
    assign o_push   = w_accept;

    // A gesture start replaces the reference points before anything is measured.
    always_comb begin
        n_first_pos = r_first_pos;
        n_first_raw = r_first_raw;
        if (i_gesture_start) begin
            n_first_pos = '{x: i_pos_x, y: i_pos_y};
            n_first_raw = '{x: i_raw_x, y: i_raw_y};
        end
    end

    // Per-axis raw distance from the first raw point against the tap tolerance.
    always_comb begin
        w_rdx = {i_raw_x[tstc_pkg::COORD_W-1], i_raw_x}
              - {n_first_raw.x[tstc_pkg::COORD_W-1], n_first_raw.x};
        w_rdy = {i_raw_y[tstc_pkg::COORD_W-1], i_raw_y}
              - {n_first_raw.y[tstc_pkg::COORD_W-1], n_first_raw.y};
        w_rdx_abs = w_rdx[tstc_pkg::DIFF_W-1] ? (~w_rdx + 1'b1) : w_rdx;
        w_rdy_abs = w_rdy[tstc_pkg::DIFF_W-1] ? (~w_rdy + 1'b1) : w_rdy;
        w_exceed = (w_rdx_abs > tstc_pkg::DIFF_W'(i_tap_tol))
                || (w_rdy_abs > tstc_pkg::DIFF_W'(i_tap_tol));
        n_tap = (i_gesture_start ? 1'b1 : r_tap) && !w_exceed;
    end

    // Point count restarts at one and saturates one past the history depth.
    always_comb begin
        if (i_gesture_start) begin
            n_count = tstc_pkg::CNT_W'(1);
        end else if (r_count < tstc_pkg::CNT_W'(tstc_pkg::HISTORY_DEPTH + 1)) begin
            n_count = r_count + 1'b1;
        end else begin
            n_count = r_count;
        end
    end

    // Vectors to the latest point, from the first point and from the oldest stored one.
    always_comb begin
        o_ent.still_tap  = n_tap;
        o_ent.use_recent = n_count > tstc_pkg::CNT_W'(tstc_pkg::HISTORY_DEPTH);
        o_ent.ovr.dx = {i_pos_x[tstc_pkg::COORD_W-1], i_pos_x}
                     - {n_first_pos.x[tstc_pkg::COORD_W-1], n_first_pos.x};
        o_ent.ovr.dy = {i_pos_y[tstc_pkg::COORD_W-1], i_pos_y}
                     - {n_first_pos.y[tstc_pkg::COORD_W-1], n_first_pos.y};
        o_ent.rec.dx = {i_pos_x[tstc_pkg::COORD_W-1], i_pos_x}
                     - {r_hist[tstc_pkg::HIST_LEN-1].x[tstc_pkg::COORD_W-1],
                        r_hist[tstc_pkg::HIST_LEN-1].x};
        o_ent.rec.dy = {i_pos_y[tstc_pkg::COORD_W-1], i_pos_y}
                     - {r_hist[tstc_pkg::HIST_LEN-1].y[tstc_pkg::COORD_W-1],
                        r_hist[tstc_pkg::HIST_LEN-1].y};
    end

    // Gesture state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_pos <= '0;
            r_first_raw <= '0;
            r_tap       <= 1'b1;
            r_count     <= '0;
        end else if (w_accept) begin
            r_first_pos <= n_first_pos;
            r_first_raw <= n_first_raw;
            r_tap       <= n_tap;
            r_count     <= n_count;
        end
    end

    // Shift line of the latest points; entries are read only once written.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hist[0] <= '{x: i_pos_x, y: i_pos_y};
            for (int i = 1; i < tstc_pkg::HIST_LEN; i++) begin
                r_hist[i] <= r_hist[i-1];
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/tstc_queue.sv @@
`default_nettype none

module tstc_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  tstc_pkg::t_qent      i_ent,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_empty,
    output tstc_pkg::t_qent      o_ent
);

    tstc_pkg::t_qent r_mem [tstc_pkg::QUEUE_DEPTH];
    logic [tstc_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [tstc_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [tstc_pkg::QCNT_W-1:0] r_count;
    logic w_push;
    logic w_pop;

    assign o_full  = r_count == tstc_pkg::QCNT_W'(tstc_pkg::QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_ent   = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    // Pointers wrap at the queue depth.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == tstc_pkg::QPTR_W'(tstc_pkg::QUEUE_DEPTH - 1))
                          ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == tstc_pkg::QPTR_W'(tstc_pkg::QUEUE_DEPTH - 1))
                          ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_ent;
        end
    end

endmodule

`default_nettype wire

@@ rtl/tstc_back.sv @@
`default_nettype none

module tstc_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  tstc_pkg::t_cls_cfg   i_cfg,
    input  wire logic            i_empty,
    input  tstc_pkg::t_qent      i_ent,
    output logic                 o_pop,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output logic                 o_still_tap,
    output logic [2:0]           o_overall_code,
    output logic [2:0]           o_recent_code
);

    tstc_pkg::t_bstate r_state;
    tstc_pkg::t_bstate n_state;

    tstc_pkg::t_qent r_ent;
    logic r_sel;
    logic r_zero;
    logic r_neg_x;
    logic r_neg_y;
    logic [tstc_pkg::SQ_W-1:0] r_sqx;
    logic [tstc_pkg::SQ_W-1:0] r_sqy;
    logic [tstc_pkg::LEN_W-1:0] r_len;
    logic [tstc_pkg::PROD_W-1:0] r_sin_l;
    logic [tstc_pkg::PROD_W-1:0] r_cos_l;
    logic [tstc_pkg::MIN_SQ_W-1:0] r_min_sq;
    tstc_pkg::t_dir r_overall;
    tstc_pkg::t_dir r_recent;

    logic r_o_valid;
    logic r_o_tap;
    tstc_pkg::t_dir r_o_overall;
    tstc_pkg::t_dir r_o_recent;

    tstc_pkg::t_vec w_vec;
    logic w_zero;
    logic [tstc_pkg::DIFF_W-1:0] w_abs_x;
    logic [tstc_pkg::DIFF_W-1:0] w_abs_y;
    logic [tstc_pkg::PROD_W-1:0] w_xq;
    logic w_narrow;
    logic w_wide;
    tstc_pkg::t_dir w_code;
    logic w_reached;
    logic w_more;
    logic w_load_out;

    assign o_valid        = r_o_valid;
    assign o_still_tap    = r_o_tap;
    assign o_overall_code = r_o_overall;
    assign o_recent_code  = r_o_recent;

    // Vector under work; a zero vector is taken as pointing right.
    always_comb begin
        w_vec   = r_sel ? r_ent.rec : r_ent.ovr;
        w_zero  = (w_vec.dx == '0) && (w_vec.dy == '0);
        w_abs_x = w_zero ? tstc_pkg::DIFF_W'(1)
                : (w_vec.dx[tstc_pkg::DIFF_W-1] ? (~w_vec.dx + 1'b1) : w_vec.dx);
        w_abs_y = w_vec.dy[tstc_pkg::DIFF_W-1] ? (~w_vec.dy + 1'b1) : w_vec.dy;
    end

    // Angle tests on registered products, checked in priority order.
    always_comb begin
        w_xq     = tstc_pkg::PROD_W'({r_sqx, {tstc_pkg::Q16_SHIFT{1'b0}}});
        w_narrow = w_xq <= r_sin_l;
        w_wide   = w_xq >= r_cos_l;
        priority if (!r_neg_y && w_narrow) begin
            w_code = tstc_pkg::DIR_DOWN;
        end else if (r_neg_x && w_wide) begin
            w_code = tstc_pkg::DIR_LEFT;
        end else if (r_neg_y && w_narrow) begin
            w_code = tstc_pkg::DIR_UP;
        end else if (!r_neg_x && w_wide) begin
            w_code = tstc_pkg::DIR_RIGHT;
        end else begin
            w_code = tstc_pkg::DIR_UNKNOWN;
        end
        // A zero vector has true length zero.
        w_reached = r_zero ? (r_min_sq == '0)
                  : (r_len >= tstc_pkg::LEN_W'(r_min_sq));
        w_more = !r_sel && w_reached && r_ent.use_recent;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tstc_pkg::S_IDLE: if (!i_empty) n_state = tstc_pkg::S_SQ;
            tstc_pkg::S_SQ:   n_state = tstc_pkg::S_SUM;
            tstc_pkg::S_SUM:  n_state = tstc_pkg::S_MUL;
            tstc_pkg::S_MUL:  n_state = tstc_pkg::S_DEC;
            tstc_pkg::S_DEC:  n_state = w_more ? tstc_pkg::S_SQ : tstc_pkg::S_OUT;
            tstc_pkg::S_OUT:  if (!r_o_valid || !i_stall) n_state = tstc_pkg::S_IDLE;
            default:          n_state = tstc_pkg::S_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_pop      = 1'b0;
        w_load_out = 1'b0;
        unique case (r_state)
            tstc_pkg::S_IDLE: o_pop = !i_empty;
            tstc_pkg::S_OUT:  w_load_out = !r_o_valid || !i_stall;
            default: begin
                o_pop      = 1'b0;
                w_load_out = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tstc_pkg::S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Shared squaring and scaling unit, one step per state.
    always_ff @(posedge i_clk) begin
        r_min_sq <= i_cfg.min_len * i_cfg.min_len;
        if (o_pop) begin
            r_ent <= i_ent;
            r_sel <= 1'b0;
        end
        if (r_state == tstc_pkg::S_SQ) begin
            r_zero  <= w_zero;
            r_neg_x <= !w_zero && w_vec.dx[tstc_pkg::DIFF_W-1];
            r_neg_y <= w_vec.dy[tstc_pkg::DIFF_W-1];
            r_sqx   <= w_abs_x[tstc_pkg::COORD_W-1:0] * w_abs_x[tstc_pkg::COORD_W-1:0];
            r_sqy   <= w_abs_y[tstc_pkg::COORD_W-1:0] * w_abs_y[tstc_pkg::COORD_W-1:0];
        end
        if (r_state == tstc_pkg::S_SUM) begin
            r_len <= tstc_pkg::LEN_W'(r_sqx) + tstc_pkg::LEN_W'(r_sqy);
        end
        if (r_state == tstc_pkg::S_MUL) begin
            r_sin_l <= i_cfg.sin_sq * r_len;
            r_cos_l <= i_cfg.cos_sq * r_len;
        end
        if (r_state == tstc_pkg::S_DEC) begin
            if (r_sel) begin
                r_recent <= w_code;
            end else if (w_more) begin
                r_overall <= w_code;
                r_sel     <= 1'b1;
            end else begin
                r_overall <= w_reached ? w_code : tstc_pkg::DIR_UNKNOWN;
                r_recent  <= w_reached ? w_code : tstc_pkg::DIR_UNKNOWN;
            end
        end
    end

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_o_tap     <= r_ent.still_tap;
            r_o_overall <= r_overall;
            r_o_recent  <= r_recent;
        end
    end

endmodule

`default_nettype wire

@@ rtl/touch_swipe_tap_classifier_unit.sv @@
// An accepted point is queued; the back part pops it in S_IDLE, runs S_SQ, S_SUM,
// S_MUL and S_DEC, again for any recent stretch, then loads the output in S_OUT.
// It takes a new word only once back in S_IDLE: the shared square/scale unit of
// the classifier handles one vector at a time; the queue holds words meanwhile.
// Reset (synchronous, active low) clears the gesture state, the queue and the
// output valid, and loads the register defaults; point history is not cleared.
`default_nettype none

module touch_swipe_tap_classifier_unit (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    output logic                                       o_stall,
    input  wire logic                                  i_gesture_start,
    input  wire logic signed [tstc_pkg::COORD_W-1:0]   i_pos_x,
    input  wire logic signed [tstc_pkg::COORD_W-1:0]   i_pos_y,
    input  wire logic signed [tstc_pkg::COORD_W-1:0]   i_raw_x,
    input  wire logic signed [tstc_pkg::COORD_W-1:0]   i_raw_y,
    input  wire logic                                  i_cfg_we,
    input  wire logic [tstc_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [tstc_pkg::CFG_W-1:0]            i_cfg_data,
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output logic                                       o_still_tap,
    output logic [2:0]                                 o_overall_code,
    output logic [2:0]                                 o_recent_code
);

    logic [tstc_pkg::LEN_CFG_W-1:0] r_tap_tol;
    tstc_pkg::t_cls_cfg r_cls_cfg;

    tstc_pkg::t_qent w_push_ent;
    tstc_pkg::t_qent w_pop_ent;
    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_empty;

    assign o_stall = w_full;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_tol         <= tstc_pkg::TAP_TOL_RST;
            r_cls_cfg.min_len <= tstc_pkg::MIN_LEN_RST;
            r_cls_cfg.cos_sq  <= tstc_pkg::COS_SQ_RST;
            r_cls_cfg.sin_sq  <= tstc_pkg::SIN_SQ_RST;
        end else if (i_cfg_we) begin
            unique case (tstc_pkg::t_cfg_idx'(i_cfg_idx))
                tstc_pkg::CFG_TAP_TOL:
                    r_tap_tol <= i_cfg_data[tstc_pkg::LEN_CFG_W-1:0];
                tstc_pkg::CFG_MIN_LEN:
                    r_cls_cfg.min_len <= i_cfg_data[tstc_pkg::LEN_CFG_W-1:0];
                tstc_pkg::CFG_COS_SQ:
                    r_cls_cfg.cos_sq <= i_cfg_data[tstc_pkg::TRIG_W-1:0];
                tstc_pkg::CFG_SIN_SQ:
                    r_cls_cfg.sin_sq <= i_cfg_data[tstc_pkg::TRIG_W-1:0];
                default: r_tap_tol <= r_tap_tol;
            endcase
        end
    end

    // Front part: gesture tracking and vector forming.
    tstc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_tap_tol       (r_tap_tol),
        .i_valid         (i_valid),
        .i_full          (w_full),
        .i_gesture_start (i_gesture_start),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_raw_x         (i_raw_x),
        .i_raw_y         (i_raw_y),
        .o_ent           (w_push_ent),
        .o_push          (w_push)
    );

    // Decoupling queue.
    tstc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_ent   (w_push_ent),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_ent   (w_pop_ent)
    );

    // Back part: direction classification and output register.
    tstc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cls_cfg),
        .i_empty        (w_empty),
        .i_ent          (w_pop_ent),
        .o_pop          (w_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_still_tap    (o_still_tap),
        .o_overall_code (o_overall_code),
        .o_recent_code  (o_recent_code)
    );

endmodule

`default_nettype wire
